### src/aadcm_pkg.sv
package aadcm_pkg;

    localparam int SINE_STAGES_DEF = 16;
    localparam int MIN_STAGES      = 8;
    localparam int MAX_STAGES      = 24;
    localparam int STAGE_IDX_W     = 5;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // atan of 2^-i in 2^32-per-turn units
    function automatic logic signed [31:0] atan_turn(input logic [STAGE_IDX_W-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // cordic gain correction for n stages, Q2.30
    function automatic logic signed [33:0] cordic_gain(input int n);
        logic [63:0] t;
        t = (64'd434688583 + (64'd1 << (2 * n - 1))) >> (2 * n);
        return 34'sd652032874 + $signed({2'b00, t[31:0]});
    endfunction

    function automatic int clamp_stages(input int n);
        if (n < MIN_STAGES) return MIN_STAGES;
        if (n > MAX_STAGES) return MAX_STAGES;
        return n;
    endfunction

endpackage

### src/aadcm_cordic.sv
module aadcm_cordic
    import aadcm_pkg::*;
#(
    parameter int SINE_STAGES = SINE_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [15:0] angle,
    output logic               out_valid,
    output logic signed [33:0] cos_q30,
    output logic signed [33:0] sin_q30
);

    localparam int N = clamp_stages(SINE_STAGES);

    // stage 0 registers the folded angle, stages 1..N iterate, stage N+1 unfolds
    logic               vld_reg  [N+2];
    logic signed [33:0] x_reg    [N+1];
    logic signed [33:0] y_reg    [N+1];
    logic signed [33:0] z_reg    [N+1];
    logic               flip_reg [N+1];
    logic signed [33:0] cos_reg, sin_reg;

    logic signed [33:0] z0_next;
    logic               flip_next;

    always_comb
    begin
        z0_next   = $signed({{2{angle[15]}}, angle, 16'd0});
        flip_next = 1'b0;
        if (z0_next > 34'sd1073741824)
        begin
            z0_next   = z0_next - 34'sd2147483648;
            flip_next = 1'b1;
        end
        else if (z0_next < -34'sd1073741824)
        begin
            z0_next   = z0_next + 34'sd2147483648;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N + 2; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < N + 2; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= cordic_gain(N);
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next;
            flip_reg[0] <= flip_next;
            for (int k = 0; k < N; k++)
            begin
                flip_reg[k+1] <= flip_reg[k];
                if (z_reg[k] >= 0)
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - 34'(atan_turn(STAGE_IDX_W'(k)));
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + 34'(atan_turn(STAGE_IDX_W'(k)));
                end
            end
            cos_reg <= flip_reg[N] ? -x_reg[N] : x_reg[N];
            sin_reg <= flip_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    assign out_valid = vld_reg[N+1];
    assign cos_q30   = cos_reg;
    assign sin_q30   = sin_reg;

endmodule

### src/aadcm_matrix.sv
module aadcm_matrix
    import aadcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [15:0] ex,
    input  logic signed [15:0] ey,
    input  logic signed [15:0] ez,
    input  logic signed [33:0] cos_q30,
    input  logic signed [33:0] sin_q30,
    input  logic               transpose,
    output logic               out_valid,
    output logic signed [15:0] elem [9],
    output logic               clipped
);

    // stage a: axis products and d = 1 - c
    logic               va_reg;
    logic signed [31:0] pp_reg [6];   // xx yy zz xy xz yz
    logic signed [34:0] d_reg;
    logic signed [33:0] ca_reg, sa_reg;
    logic signed [15:0] ea_reg [3];

    // stage b: partial products in Q58
    logic               vb_reg;
    logic signed [67:0] dd_reg [6];
    logic signed [67:0] ss_reg [3];
    logic signed [67:0] cc_reg;

    // stage c: entry sums
    logic               vc_reg;
    logic signed [68:0] m_reg [9];

    // stage d: rounded outputs
    logic               vd_reg;
    logic signed [15:0] q_reg [9];
    logic               clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    logic signed [68:0] mt      [9];
    logic signed [68:0] rnd;
    logic signed [24:0] r25;
    logic signed [15:0] q_next  [9];
    logic               clip_next;

    always_comb
    begin
        // row-major dcm entries, then optional transpose
        logic signed [68:0] m [9];
        m[0] = 69'(dd_reg[0]) + 69'(cc_reg);
        m[1] = 69'(dd_reg[3]) + 69'(ss_reg[2]);
        m[2] = 69'(dd_reg[4]) - 69'(ss_reg[1]);
        m[3] = 69'(dd_reg[3]) - 69'(ss_reg[2]);
        m[4] = 69'(dd_reg[1]) + 69'(cc_reg);
        m[5] = 69'(dd_reg[5]) + 69'(ss_reg[0]);
        m[6] = 69'(dd_reg[4]) + 69'(ss_reg[1]);
        m[7] = 69'(dd_reg[5]) - 69'(ss_reg[0]);
        m[8] = 69'(dd_reg[2]) + 69'(cc_reg);
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mt[r*3+k] = transpose ? m[k*3+r] : m[r*3+k];
            end
        end
    end

    always_comb
    begin
        clip_next = 1'b0;
        rnd       = '0;
        r25       = '0;
        for (int k = 0; k < 9; k++)
        begin
            rnd = m_reg[k] + (69'sd1 <<< 43);
            r25 = rnd[68:44];
            if (r25 > 25'sd16384)
            begin
                q_next[k] = ONE_Q14;
                clip_next = 1'b1;
            end
            else if (r25 < -25'sd16384)
            begin
                q_next[k] = -ONE_Q14;
                clip_next = 1'b1;
            end
            else
            begin
                q_next[k] = r25[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg[0] <= ex * ex;
            pp_reg[1] <= ey * ey;
            pp_reg[2] <= ez * ez;
            pp_reg[3] <= ex * ey;
            pp_reg[4] <= ex * ez;
            pp_reg[5] <= ey * ez;
            d_reg     <= 35'sd1073741824 - 35'(cos_q30);
            ca_reg    <= cos_q30;
            sa_reg    <= sin_q30;
            ea_reg[0] <= ex;
            ea_reg[1] <= ey;
            ea_reg[2] <= ez;

            for (int k = 0; k < 6; k++)
            begin
                dd_reg[k] <= 68'(pp_reg[k]) * 68'(d_reg);
            end
            for (int k = 0; k < 3; k++)
            begin
                ss_reg[k] <= (68'(ea_reg[k]) * 68'(sa_reg)) <<< 14;
            end
            cc_reg <= 68'(ca_reg) <<< 28;

            m_reg    <= mt;
            q_reg    <= q_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = vd_reg;
    assign elem      = q_reg;
    assign clipped   = clip_reg;

    always_ff @(posedge clk)
    begin
        if (rst_n && vd_reg)
        begin
            for (int k = 0; k < 9; k++)
            begin
                assert (q_reg[k] <= ONE_Q14 && q_reg[k] >= -ONE_Q14)
                    else $error("entry out of range");
            end
        end
    end

    ap_adv_vld: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vd_reg)) else $error("valid moved while held");
    ap_clip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(clip_reg)) else $error("clip moved while held");
    ap_vc_vd: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vc_reg |=> vd_reg) else $error("item lost in last stage");

endmodule

### src/axis_angle_to_rotation_matrix_top.sv
// an accepted input passes through the cordic pipeline and then matrix stages a to d before its result is valid
// throughput: one transaction per cycle while the output is not stalled, as the cordic pipeline is fully unrolled
// the whole pipeline advances when the output register is empty or its result is taken
// reset: rst_n clears all valid bits and transpose_reg to 0
module axis_angle_to_rotation_matrix_top
    import aadcm_pkg::*;
#(
    parameter int SINE_STAGES = SINE_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [15:0] rot_angle,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] elem_r0_c0,
    output logic signed [15:0] elem_r0_c1,
    output logic signed [15:0] elem_r0_c2,
    output logic signed [15:0] elem_r1_c0,
    output logic signed [15:0] elem_r1_c1,
    output logic signed [15:0] elem_r1_c2,
    output logic signed [15:0] elem_r2_c0,
    output logic signed [15:0] elem_r2_c1,
    output logic signed [15:0] elem_r2_c2,
    output logic               clipped
);

    logic transpose_reg;
    logic adv;

    // axis delay line to line up with the cordic output
    localparam int N   = clamp_stages(SINE_STAGES);
    localparam int DLY = N + 2;

    logic signed [15:0] ax_reg [DLY];
    logic signed [15:0] ay_reg [DLY];
    logic signed [15:0] az_reg [DLY];

    logic               cv;
    logic signed [33:0] cos_q30, sin_q30;
    logic signed [15:0] elem [9];

    // global advance: last stage empty or its result taken
    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transpose_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            transpose_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg[0] <= axis_x;
            ay_reg[0] <= axis_y;
            az_reg[0] <= axis_z;
            for (int k = 1; k < DLY; k++)
            begin
                ax_reg[k] <= ax_reg[k-1];
                ay_reg[k] <= ay_reg[k-1];
                az_reg[k] <= az_reg[k-1];
            end
        end
    end

    aadcm_cordic #(.SINE_STAGES(SINE_STAGES)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .angle     (rot_angle),
        .out_valid (cv),
        .cos_q30   (cos_q30),
        .sin_q30   (sin_q30)
    );

    aadcm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cv),
        .ex        (ax_reg[DLY-1]),
        .ey        (ay_reg[DLY-1]),
        .ez        (az_reg[DLY-1]),
        .cos_q30   (cos_q30),
        .sin_q30   (sin_q30),
        .transpose (transpose_reg),
        .out_valid (out_valid),
        .elem      (elem),
        .clipped   (clipped)
    );

    assign elem_r0_c0 = elem[0];
    assign elem_r0_c1 = elem[1];
    assign elem_r0_c2 = elem[2];
    assign elem_r1_c0 = elem[3];
    assign elem_r1_c1 = elem[4];
    assign elem_r1_c2 = elem[5];
    assign elem_r2_c0 = elem[6];
    assign elem_r2_c1 = elem[7];
    assign elem_r2_c2 = elem[8];

endmodule
